// File: hdl/ssr_pkg.sv
// Shared types and constants for the stepper sequencer with ramp.
// Holds op codes, register indexes, reset values and the coil pattern table.
// No dependencies.
package ssr_pkg;

    localparam int CNT_W     = 16;
    localparam int DELAY_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int PHASE_W   = 3;
    localparam int COIL_W    = 4;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_MOVE = 2'd1,
        OP_GOTO = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP      = 2'd2;

    localparam logic [DELAY_W-1:0] MIN_DELAY_RST  = 16'd800;
    localparam logic [DELAY_W-1:0] MAX_DELAY_RST  = 16'd3000;
    localparam logic [CNT_W-1:0]   RAMP_STEPS_RST = 16'd200;

    // goto distances are rounded down to an even count
    localparam logic [CNT_W-1:0] GOTO_EVEN_MASK = 16'hFFFE;

    typedef struct packed {
        logic [DELAY_W-1:0] min_delay_us;
        logic [DELAY_W-1:0] max_delay_us;
        logic [CNT_W-1:0]   ramp_steps;
    } ramp_cfg_t;

    // half-step coil pattern, coils A,B,C,D from msb
    function automatic logic [COIL_W-1:0] coil_f(input logic [PHASE_W-1:0] phase);
        logic [COIL_W-1:0] pat;
        begin
            case (phase)
                3'd0:    pat = 4'h8;
                3'd1:    pat = 4'hC;
                3'd2:    pat = 4'h4;
                3'd3:    pat = 4'h6;
                3'd4:    pat = 4'h2;
                3'd5:    pat = 4'h3;
                3'd6:    pat = 4'h1;
                default: pat = 4'h9;
            endcase
            return pat;
        end
    endfunction

endpackage

// File: hdl/stepper_sequencer_with_ramp_core.sv
// Top level of the half-step stepper sequencer with quadratic ramp.
// Depends on ssr_pkg and ssr_ramp (which uses ssr_mul and ssr_div).
//
// Input channel (in_valid / in_stall) carries one command item: op, direction,
// step_count, target_position. Op tick steps the motor; op move and op goto load
// a new move while the motor is idle. The output channel (out_valid / out_stall)
// returns exactly one result item per input item. Write the registers through
// cfg_we / cfg_index / cfg_data only while idle: index 0 min_delay_us,
// 1 max_delay_us, 2 ramp_steps; index 3 is ignored.
// A tick that steps while the ramp count is below ramp_steps has its delay worked
// out by the ramp unit: two serial multiplies side by side (squares of the
// remaining ramp and of ramp_steps), a serial multiply by the delay span and a
// serial divide, before the push state loads the output register. Every other
// item goes from accept through the push state into the output register. The next
// item is taken once the sequencer is back in idle. One item is in work at a time.
// Reset: rst_n clears the motor state (phase, position, counts, idle) and sets
// the registers to min 800, max 3000, ramp 200.
// Stall: while out_stall holds a result, the next result waits in the sequencer
// and in_stall stays high until the output register frees.
module stepper_sequencer_with_ramp_core #(
    parameter int POSITION_STEPS = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // command channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          op,
    input  logic                                direction,
    input  logic [ssr_pkg::CNT_W-1:0]           step_count,
    input  logic [$clog2(POSITION_STEPS)-1:0]   target_position,
    // result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [ssr_pkg::COIL_W-1:0]          coil_pattern,
    output logic [ssr_pkg::DELAY_W-1:0]         step_delay_us,
    output logic                                stepped,
    output logic                                busy_res,
    output logic                                accepted,
    output logic [$clog2(POSITION_STEPS)-1:0]   position,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [ssr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ssr_pkg::DELAY_W-1:0]         cfg_data
);

    localparam int POS_W = $clog2(POSITION_STEPS);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(POSITION_STEPS - 1);
    localparam int CW = ssr_pkg::CNT_W;
    localparam int DW = ssr_pkg::DELAY_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RAMP,
        S_PUSH
    } state_t;

    state_t                          state_reg, state_next;
    // motor state
    logic [ssr_pkg::PHASE_W-1:0]     phase_reg, phase_next;
    logic [CW-1:0]                   remaining_reg, remaining_next;
    logic [CW-1:0]                   ramp_cnt_reg, ramp_cnt_next;
    logic                            dir_reg, dir_next;
    logic                            busy_reg, busy_next;
    logic [POS_W-1:0]                pos_reg, pos_next;
    // configuration
    ssr_pkg::ramp_cfg_t              cfg_reg, cfg_next;
    // per-item result parts not taken from the motor state
    logic                            step_flag_reg, step_flag_next;
    logic                            acc_flag_reg, acc_flag_next;
    logic [DW-1:0]                   delay_reg, delay_next;
    // output register
    logic                            out_valid_reg, out_valid_next;
    logic [ssr_pkg::COIL_W-1:0]      coil_pattern_reg, coil_pattern_next;
    logic [DW-1:0]                   step_delay_reg, step_delay_next;
    logic                            stepped_reg, stepped_next;
    logic                            busy_res_reg, busy_res_next;
    logic                            accepted_reg, accepted_next;
    logic [POS_W-1:0]                position_reg, position_next;

    logic                            ramp_start;
    logic                            ramp_done;
    logic [DW-1:0]                   ramp_delay;
    logic [POS_W-1:0]                goto_dist;
    logic                            goto_down;

    // goto: distance to target and direction, before even rounding
    assign goto_down = target_position > pos_reg;
    assign goto_dist = goto_down ? (target_position - pos_reg) : (pos_reg - target_position);

    ssr_ramp u_ramp (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ramp_start),
        .n        (ramp_cnt_reg),
        .cfg      (cfg_reg),
        .done     (ramp_done),
        .delay_us (ramp_delay)
    );

    always_comb
    begin
        state_next        = state_reg;
        phase_next        = phase_reg;
        remaining_next    = remaining_reg;
        ramp_cnt_next     = ramp_cnt_reg;
        dir_next          = dir_reg;
        busy_next         = busy_reg;
        pos_next          = pos_reg;
        cfg_next          = cfg_reg;
        step_flag_next    = step_flag_reg;
        acc_flag_next     = acc_flag_reg;
        delay_next        = delay_reg;
        coil_pattern_next = coil_pattern_reg;
        step_delay_next   = step_delay_reg;
        stepped_next      = stepped_reg;
        busy_res_next     = busy_res_reg;
        accepted_next     = accepted_reg;
        position_next     = position_reg;
        ramp_start        = 1'b0;

        // drop the held result once the receiver takes it
        out_valid_next = out_valid_reg & out_stall;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    step_flag_next = 1'b0;
                    acc_flag_next  = 1'b0;
                    delay_next     = '0;
                    state_next     = S_PUSH;
                    unique case (ssr_pkg::op_t'(op))
                        ssr_pkg::OP_TICK:
                        begin
                            if (remaining_reg != '0)
                            begin
                                busy_next      = 1'b1;
                                step_flag_next = 1'b1;
                                remaining_next = remaining_reg - 1'b1;
                                if (!dir_reg)
                                begin
                                    phase_next = phase_reg + 1'b1;
                                    pos_next   = (pos_reg == '0) ? POS_LAST : pos_reg - 1'b1;
                                end
                                else
                                begin
                                    phase_next = phase_reg - 1'b1;
                                    pos_next   = (pos_reg == POS_LAST) ? '0 : pos_reg + 1'b1;
                                end
                                // still on the ramp: start the serial delay calculation
                                if (ramp_cnt_reg < cfg_reg.ramp_steps)
                                begin
                                    ramp_cnt_next = ramp_cnt_reg + 1'b1;
                                    ramp_start    = 1'b1;
                                    state_next    = S_RAMP;
                                end
                                else
                                begin
                                    delay_next = cfg_reg.min_delay_us;
                                end
                            end
                            else
                            begin
                                busy_next = 1'b0;
                            end
                        end
                        ssr_pkg::OP_MOVE:
                        begin
                            if (!busy_reg)
                            begin
                                dir_next       = direction;
                                remaining_next = step_count;
                                ramp_cnt_next  = '0;
                                acc_flag_next  = 1'b1;
                            end
                        end
                        ssr_pkg::OP_GOTO:
                        begin
                            if (!busy_reg)
                            begin
                                dir_next       = goto_down;
                                remaining_next = CW'(goto_dist) & ssr_pkg::GOTO_EVEN_MASK;
                                ramp_cnt_next  = '0;
                                acc_flag_next  = 1'b1;
                            end
                        end
                        ssr_pkg::OP_NONE:
                        begin
                        end
                    endcase
                end
            end
            S_RAMP:
            begin
                if (ramp_done)
                begin
                    delay_next = ramp_delay;
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                // load the output register once it is free
                if (!(out_valid_reg && out_stall))
                begin
                    out_valid_next    = 1'b1;
                    coil_pattern_next = busy_reg ? ssr_pkg::coil_f(phase_reg) : '0;
                    step_delay_next   = delay_reg;
                    stepped_next      = step_flag_reg;
                    busy_res_next     = busy_reg;
                    accepted_next     = acc_flag_reg;
                    position_next     = pos_reg;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            unique case (cfg_index)
                ssr_pkg::CFG_MIN_DELAY: cfg_next.min_delay_us = cfg_data;
                ssr_pkg::CFG_MAX_DELAY: cfg_next.max_delay_us = cfg_data;
                ssr_pkg::CFG_RAMP:      cfg_next.ramp_steps   = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= S_IDLE;
            phase_reg            <= '0;
            remaining_reg        <= '0;
            ramp_cnt_reg         <= '0;
            dir_reg              <= 1'b0;
            busy_reg             <= 1'b0;
            pos_reg              <= '0;
            cfg_reg.min_delay_us <= ssr_pkg::MIN_DELAY_RST;
            cfg_reg.max_delay_us <= ssr_pkg::MAX_DELAY_RST;
            cfg_reg.ramp_steps   <= ssr_pkg::RAMP_STEPS_RST;
            step_flag_reg        <= 1'b0;
            acc_flag_reg         <= 1'b0;
            delay_reg            <= '0;
            out_valid_reg        <= 1'b0;
            coil_pattern_reg     <= '0;
            step_delay_reg       <= '0;
            stepped_reg          <= 1'b0;
            busy_res_reg         <= 1'b0;
            accepted_reg         <= 1'b0;
            position_reg         <= '0;
        end
        else
        begin
            state_reg            <= state_next;
            phase_reg            <= phase_next;
            remaining_reg        <= remaining_next;
            ramp_cnt_reg         <= ramp_cnt_next;
            dir_reg              <= dir_next;
            busy_reg             <= busy_next;
            pos_reg              <= pos_next;
            cfg_reg              <= cfg_next;
            step_flag_reg        <= step_flag_next;
            acc_flag_reg         <= acc_flag_next;
            delay_reg            <= delay_next;
            out_valid_reg        <= out_valid_next;
            coil_pattern_reg     <= coil_pattern_next;
            step_delay_reg       <= step_delay_next;
            stepped_reg          <= stepped_next;
            busy_res_reg         <= busy_res_next;
            accepted_reg         <= accepted_next;
            position_reg         <= position_next;
        end
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign coil_pattern  = coil_pattern_reg;
    assign step_delay_us = step_delay_reg;
    assign stepped       = stepped_reg;
    assign busy_res      = busy_res_reg;
    assign accepted      = accepted_reg;
    assign position      = position_reg;

`ifndef NO_ASSERTIONS
    a_ramp_done_in_ramp: assert property (@(posedge clk) disable iff (!rst_n)
        ramp_done |-> state_reg == S_RAMP)
        else $error("ramp unit finished outside the ramp state");

    a_rise_from_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_PUSH))
        else $error("result appeared without a push");

    a_busy_coils_on: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && busy_res_reg |-> coil_pattern_reg != '0)
        else $error("busy motor reported with coils off");

    a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && stepped_reg |-> busy_res_reg && !accepted_reg)
        else $error("step reported without busy or with a command taken");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, pos_reg} <= {1'b0, POS_LAST})
        else $error("position out of range");
`endif

endmodule

// File: hdl/ssr_mul.sv
// Bit-serial shift-add multiplier: one bit of b per cycle.
// Product holds after done until the next start. No dependencies.
module ssr_mul #(
    parameter int A_W = 16,
    parameter int B_W = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic               done,
    output logic [A_W+B_W-1:0] product
);

    localparam int CW = $clog2(B_W + 1);

    logic [A_W-1:0]     a_reg, a_next;
    logic [A_W+B_W-1:0] prod_reg, prod_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               run_reg, run_next;
    logic               done_reg, done_next;
    logic [A_W:0]       sum;

    // add a into the upper part when the current multiplier bit is set
    assign sum = {1'b0, prod_reg[A_W+B_W-1:B_W]} + (prod_reg[0] ? {1'b0, a_reg} : '0);

    always_comb
    begin
        a_next    = a_reg;
        prod_next = prod_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            a_next    = a;
            prod_next = {{A_W{1'b0}}, b};
            cnt_next  = CW'(B_W);
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            prod_next = {sum, prod_reg[B_W-1:1]};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        prod_reg <= prod_next;
    end

    assign done    = done_reg;
    assign product = prod_reg;

endmodule

// File: hdl/ssr_div.sv
// Restoring serial divider: one quotient bit per cycle.
// Requires num < den * 2**Q_W, so the quotient fits in Q_W bits. No dependencies.
module ssr_div #(
    parameter int D_W = 32,
    parameter int Q_W = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [D_W+Q_W-1:0] num,
    input  logic [D_W-1:0]     den,
    output logic               done,
    output logic [Q_W-1:0]     quot
);

    localparam int CW = $clog2(Q_W + 1);

    logic [D_W-1:0] rem_reg, rem_next;
    logic [D_W-1:0] den_reg, den_next;
    logic [Q_W-1:0] q_reg, q_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           run_reg, run_next;
    logic           done_reg, done_next;
    logic [D_W:0]   trial;
    logic [D_W:0]   diff;
    logic           ge;

    // shift in the next dividend bit and try a subtract
    assign trial = {rem_reg, q_reg[Q_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = ~diff[D_W];

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = num[D_W+Q_W-1:Q_W];
            q_next   = num[Q_W-1:0];
            den_next = den;
            cnt_next = CW'(Q_W);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = ge ? diff[D_W-1:0] : trial[D_W-1:0];
            q_next   = {q_reg[Q_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// File: hdl/ssr_ramp.sv
// Ramp delay unit: floor((R-n)^2 * span / R^2) + min, worked out serially.
// Depends on ssr_pkg, ssr_mul and ssr_div. Caller guarantees n < R.
module ssr_ramp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [ssr_pkg::CNT_W-1:0]         n,
    input  ssr_pkg::ramp_cfg_t                cfg,
    output logic                              done,
    output logic [ssr_pkg::DELAY_W-1:0]       delay_us
);

    localparam int W = ssr_pkg::CNT_W;

    logic [W-1:0]   left;
    logic [W-1:0]   span;
    logic [2*W-1:0] left_sq;
    logic [2*W-1:0] r_sq;
    logic [3*W-1:0] numer;
    logic [W-1:0]   extra;
    logic           sq_l_done;
    logic           sq_r_done;
    logic           sp_done;

    assign left = cfg.ramp_steps - n;
    // max below min adds nothing to the delay
    assign span = (cfg.max_delay_us > cfg.min_delay_us) ?
                  (cfg.max_delay_us - cfg.min_delay_us) : '0;

    ssr_mul #(.A_W(W), .B_W(W)) u_sq_left (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .a       (left),
        .b       (left),
        .done    (sq_l_done),
        .product (left_sq)
    );

    ssr_mul #(.A_W(W), .B_W(W)) u_sq_r (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .a       (cfg.ramp_steps),
        .b       (cfg.ramp_steps),
        .done    (sq_r_done),
        .product (r_sq)
    );

    ssr_mul #(.A_W(2*W), .B_W(W)) u_span (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sq_l_done & sq_r_done),
        .a       (left_sq),
        .b       (span),
        .done    (sp_done),
        .product (numer)
    );

    ssr_div #(.D_W(2*W), .Q_W(W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sp_done),
        .num   (numer),
        .den   (r_sq),
        .done  (done),
        .quot  (extra)
    );

    assign delay_us = extra + cfg.min_delay_us;

endmodule
